// ===== rtl/core/sbr_pkg.sv =====
// Shared constants, payload types and decode codes of the spectrum bin resizer.
`default_nettype none
package sbr_pkg;

	localparam int MAX_BINS  = 4096;
	localparam int PART_BITS = 24;
	localparam int IDX_W     = $clog2(MAX_BINS);
	localparam int REG_W     = IDX_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int BIN_W     = 2 * PART_BITS;

	localparam logic [CFG_IDX_W-1:0] REG_IN_BINS  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_OUT_BINS = CFG_IDX_W'(1);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic                        operation;
		logic [IDX_W-1:0]            bin_index;
		logic signed [PART_BITS-1:0] bin_real;
		logic signed [PART_BITS-1:0] bin_imag;
	} req_item_t;

	typedef struct packed {
		logic signed [PART_BITS-1:0] out_real;
		logic signed [PART_BITS-1:0] out_imag;
	} rsp_item_t;

	typedef enum logic [1:0] {
		MODE_ZERO = 2'd0,
		MODE_COPY = 2'd1,
		MODE_HALF = 2'd2,
		MODE_FOLD = 2'd3
	} rd_mode_t;

	typedef struct packed {
		logic     read;
		rd_mode_t mode;
	} rd_ctrl_t;

	function automatic logic [REG_W-1:0] clamp_bins(input logic [REG_W-1:0] v);
		logic [REG_W-1:0] r;
		if (v == '0) begin
			r = REG_W'(1);
		end else if (v > REG_W'(MAX_BINS)) begin
			r = REG_W'(MAX_BINS);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/spectrum_bin_resizer.sv =====
// Spectrum bin resizer: one input bin store, read back as a resized spectrum.
// A load is written into the store at its transfer if its index is below the clamped in_bins; it gives no result.
// A read's result passes through the store's registered read and then the output register;
// one item per cycle is sustained while rsp_ready does not stall the output.
// Reset clears the pipeline and sets in_bins and out_bins to 4096; the store is not cleared.
`default_nettype none
module spectrum_bin_resizer
	import sbr_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_item_t            req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_item_t                 rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [REG_W-1:0]     cfg_wdata
);

	logic [REG_W-1:0] in_bins_q, out_bins_q;
	logic             fire, load_we, stage_free;
	logic [IDX_W-1:0] addr_a, addr_b;
	logic [BIN_W-1:0] rdata_a, rdata_b;
	rd_ctrl_t         ctrl;

	assign req_ready = stage_free;
	assign fire      = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_bins_q  <= REG_W'(MAX_BINS);
			out_bins_q <= REG_W'(MAX_BINS);
		end else if (cfg_we) begin
			if (cfg_index == REG_IN_BINS) begin
				in_bins_q <= cfg_wdata;
			end else if (cfg_index == REG_OUT_BINS) begin
				out_bins_q <= cfg_wdata;
			end
		end
	end

	sbr_addr_gen u_addr_gen (
		.in_bins  (in_bins_q),
		.out_bins (out_bins_q),
		.fire     (fire),
		.req      (req),
		.load_we  (load_we),
		.addr_a   (addr_a),
		.addr_b   (addr_b),
		.ctrl     (ctrl)
	);

	sbr_ram #(
		.WIDTH (BIN_W),
		.DEPTH (MAX_BINS)
	) u_store (
		.clk     (clk),
		.we      (load_we),
		.waddr   (req.bin_index),
		.wdata   ({req.bin_real, req.bin_imag}),
		.re_a    (ctrl.read),
		.raddr_a (addr_a),
		.rdata_a (rdata_a),
		.re_b    (ctrl.read),
		.raddr_b (addr_b),
		.rdata_b (rdata_b)
	);

	sbr_output u_output (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.rdata_a    (rdata_a),
		.rdata_b    (rdata_b),
		.stage_free (stage_free),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

endmodule
`default_nettype wire

// ===== rtl/core/sbr_ram.sv =====
// Generic synchronous RAM with one write port and two registered read ports.
`default_nettype none
module sbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic                     re_b,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem[raddr_b];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sbr_addr_gen.sv =====
// Maps a requested output bin onto store addresses and a combine mode.
`default_nettype none
module sbr_addr_gen
	import sbr_pkg::*;
(
	input  wire logic [REG_W-1:0] in_bins,
	input  wire logic [REG_W-1:0] out_bins,
	input  wire logic             fire,
	input  wire req_item_t        req,
	output logic                  load_we,
	output logic      [IDX_W-1:0] addr_a,
	output logic      [IDX_W-1:0] addr_b,
	output rd_ctrl_t              ctrl
);

	logic [REG_W-1:0] ns, nr, m, h, k, q_up, q_dn;
	rd_mode_t         mode;

	always_comb begin
		ns   = clamp_bins(in_bins);
		nr   = clamp_bins(out_bins);
		m    = (ns < nr) ? ns : nr;
		h    = (m - REG_W'(1)) >> 1;
		k    = {1'b0, req.bin_index};
		q_up = ns >> 1;
		q_dn = nr >> 1;

		mode   = MODE_ZERO;
		addr_a = req.bin_index;
		addr_b = req.bin_index;
		if (k >= nr) begin
			mode = MODE_ZERO;
		end else if (ns == nr || k <= h) begin
			mode = MODE_COPY;
		end else if (k >= nr - h) begin
			// Top bins come from the same distance below the input's end.
			mode   = MODE_COPY;
			addr_a = IDX_W'(ns - nr + k);
		end else if (!ns[0] && nr > ns) begin
			if (k == q_up || k == nr - q_up) begin
				mode   = MODE_HALF;
				addr_a = IDX_W'(q_up);
			end
		end else if (!nr[0] && ns > nr) begin
			if (k == q_dn) begin
				mode   = MODE_FOLD;
				addr_a = IDX_W'(q_dn);
				addr_b = IDX_W'(ns - q_dn);
			end
		end

		load_we   = fire && req.operation == OP_LOAD && k < ns;
		ctrl.read = fire && req.operation == OP_READ;
		ctrl.mode = mode;
	end

endmodule
`default_nettype wire

// ===== rtl/core/sbr_output.sv =====
// Read stage tracking, combine arithmetic and output register.
`default_nettype none
module sbr_output
	import sbr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rd_ctrl_t         ctrl,
	input  wire logic [BIN_W-1:0] rdata_a,
	input  wire logic [BIN_W-1:0] rdata_b,
	output logic                  stage_free,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output rsp_item_t             rsp
);

	logic                     valid_s1;
	rd_mode_t                 mode_s1;
	logic                     advance;
	rsp_item_t                bin_a, bin_b, result;
	logic signed [PART_BITS:0] fold_sum;
	logic                     rsp_valid_q;
	rsp_item_t                rsp_q;

	assign advance    = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign stage_free = !valid_s1 || advance;
	assign rsp_valid  = rsp_valid_q;
	assign rsp        = rsp_q;

	always_comb begin
		bin_a    = rsp_item_t'(rdata_a);
		bin_b    = rsp_item_t'(rdata_b);
		fold_sum = {bin_a.out_real[PART_BITS-1], bin_a.out_real}
			+ {bin_b.out_real[PART_BITS-1], bin_b.out_real};
		result   = '0;
		unique case (mode_s1)
			MODE_ZERO: result = '0;
			MODE_COPY: result = bin_a;
			MODE_HALF: begin
				result.out_real = bin_a.out_real >>> 1;
				result.out_imag = bin_a.out_imag >>> 1;
			end
			MODE_FOLD: begin
				// Floored mean of the two folded real parts; the imaginary part is dropped.
				result.out_real = fold_sum[PART_BITS:1];
				result.out_imag = '0;
			end
			default: result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctrl.read) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.read) begin
			mode_s1 <= ctrl.mode;
		end
		if (advance) begin
			rsp_q <= result;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/sbr_checker.sv =====
// Port-level checks of the spectrum bin resizer, bound to the top level.
`default_nettype none
module sbr_checker
	import sbr_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      req_valid,
	input wire logic      req_ready,
	input wire req_item_t req,
	input wire logic      rsp_valid,
	input wire logic      rsp_ready,
	input wire rsp_item_t rsp
);

	// A result that is not taken stays on the port unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result changed or dropped while stalled");

	// With the output register empty the read stage can always drain, so requests are taken.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request side stalled with an empty output");

	// A read transfer followed by a ready output brings its result through the read stage into the output register.
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.operation == OP_READ ##1 rsp_ready |=> rsp_valid)
		else $error("read result did not arrive");

endmodule

bind spectrum_bin_resizer sbr_checker u_sbr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the spectrum bin resizer: directed table, then random resize phases.
`default_nettype none
module tb;
	import sbr_pkg::*;

	localparam int ITEM_TARGET  = 650;
	localparam int HOLD_CYCLES  = 300;
	localparam int TAIL_CYCLES  = 6;
	localparam int DRAIN_LIMIT  = 4000;
	localparam int PLAN_ROWS    = 36;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

	localparam logic signed [PART_BITS-1:0] P_MAX = 24'sd8388607;
	localparam logic signed [PART_BITS-1:0] P_MIN = -24'sd8388608;

	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] reg_sel;
		logic [REG_W-1:0]     reg_val;
		req_item_t            item;
		logic                 fixed;
		rsp_item_t            want;
	} plan_row_t;

	typedef struct packed {
		logic      fixed;
		rsp_item_t want;
	} read_note_t;

	// Directed table; rows with a fixed result carry it, the rest go to the predictor.
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{1'b0, REG_IN_BINS, '0, '{OP_LOAD, 12'd0, P_MAX, P_MIN}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd0, '0, '0}, 1'b1, '{P_MAX, P_MIN}},
		'{1'b0, REG_IN_BINS, '0, '{OP_LOAD, 12'd4095, -24'sd1, 24'sd1}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd4095, '0, '0}, 1'b1, '{-24'sd1, 24'sd1}},
		'{1'b0, REG_IN_BINS, '0, '{OP_LOAD, 12'd2, P_MIN, P_MAX}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd2, '0, '0}, 1'b1, '{P_MIN, P_MAX}},
		'{1'b1, REG_IN_BINS, 13'd8, '0, 1'b0, '0},
		'{1'b1, REG_OUT_BINS, 13'd16, '0, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_LOAD, 12'd4, -24'sd3, 24'sd5}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd4, '0, '0}, 1'b1, '{-24'sd2, 24'sd2}},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd12, '0, '0}, 1'b1, '{-24'sd2, 24'sd2}},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd16, P_MAX, P_MAX}, 1'b1, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd4095, '0, '0}, 1'b1, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd13, '0, '0}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd3, '0, '0}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd7, '0, '0}, 1'b1, '0},
		'{1'b1, REG_OUT_BINS, 13'd4, '0, 1'b0, '0},
		'{1'b1, REG_IN_BINS, 13'd6, '0, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_LOAD, 12'd2, P_MAX, 24'sd7}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_LOAD, 12'd4, P_MAX, -24'sd9}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd2, '0, '0}, 1'b1, '{P_MAX, 24'sd0}},
		'{1'b0, REG_IN_BINS, '0, '{OP_LOAD, 12'd2, P_MIN, 24'sd0}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_LOAD, 12'd4, P_MIN, 24'sd0}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd2, '0, '0}, 1'b1, '{P_MIN, 24'sd0}},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd3, '0, '0}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd4, '0, '0}, 1'b1, '0},
		'{1'b1, REG_IN_BINS, 13'd0, '0, 1'b0, '0},
		'{1'b1, REG_OUT_BINS, 13'd0, '0, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_LOAD, 12'd1, 24'sd123, 24'sd456}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd0, '0, '0}, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd1, '0, '0}, 1'b1, '0},
		'{1'b1, REG_IN_BINS, 13'd8191, '0, 1'b0, '0},
		'{1'b1, REG_OUT_BINS, 13'd1, '0, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd0, '0, '0}, 1'b0, '0},
		'{1'b1, REG_UNUSED, 13'd5, '0, 1'b0, '0},
		'{1'b0, REG_IN_BINS, '0, '{OP_READ, 12'd1, '0, '0}, 1'b1, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_item_t            req = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_item_t            rsp;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0]     cfg_wdata = '0;

	// Predictor state, updated at each transfer.
	logic signed [PART_BITS-1:0] spec_re [MAX_BINS];
	logic signed [PART_BITS-1:0] spec_im [MAX_BINS];
	logic [REG_W-1:0]            in_reg = REG_W'(MAX_BINS);
	logic [REG_W-1:0]            out_reg = REG_W'(MAX_BINS);
	rsp_item_t                   bin_due_q [$];
	read_note_t                  read_note_q [$];

	// Stimulus-side view of the sizes and of which input bins hold data.
	int gen_ns = MAX_BINS;
	int gen_nr = MAX_BINS;
	bit bin_filled [MAX_BINS];
	int burst_left = 0;
	int items_sent = 0;
	int fault_cnt = 0;
	bit hold_rsp_req = 1'b0;

	spectrum_bin_resizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic int bins_in_use(input int v);
		if (v < 1) begin
			return 1;
		end
		if (v > MAX_BINS) begin
			return MAX_BINS;
		end
		return v;
	endfunction

	function automatic rsp_item_t resized_bin(input int k);
		int        ns, nr, m, h, q, src, sum;
		rsp_item_t r;
		ns = bins_in_use(int'(in_reg));
		nr = bins_in_use(int'(out_reg));
		m = (ns < nr) ? ns : nr;
		h = (m - 1) / 2;
		r = '0;
		if (k >= nr) begin
			r = '0;
		end else if (ns == nr || k <= h) begin
			r = '{spec_re[k], spec_im[k]};
		end else if (k >= nr - h) begin
			src = ns - nr + k;
			r = '{spec_re[src], spec_im[src]};
		end else if (ns % 2 == 0 && nr > ns) begin
			// The input Nyquist bin is split in half over two output bins.
			q = ns / 2;
			if (k == q || k == nr - q) begin
				r.out_real = spec_re[q] >>> 1;
				r.out_imag = spec_im[q] >>> 1;
			end
		end else if (nr % 2 == 0 && ns > nr) begin
			// Folding two bins into the output Nyquist keeps only the real average.
			q = nr / 2;
			if (k == q) begin
				sum = int'(spec_re[q]) + int'(spec_re[ns - q]);
				r.out_real = PART_BITS'(sum >>> 1);
			end
		end
		return r;
	endfunction

	always @(posedge clk) begin
		read_note_t note;
		rsp_item_t  due;
		if (!arst_n) begin
			in_reg = REG_W'(MAX_BINS);
			out_reg = REG_W'(MAX_BINS);
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_IN_BINS: in_reg = cfg_wdata;
					REG_OUT_BINS: out_reg = cfg_wdata;
					default: ;
				endcase
			end
			if (req_valid && req_ready) begin
				if (req.operation == OP_LOAD) begin
					if (int'(req.bin_index) < bins_in_use(int'(in_reg))) begin
						spec_re[req.bin_index] = req.bin_real;
						spec_im[req.bin_index] = req.bin_imag;
					end
				end else begin
					note = (read_note_q.size() != 0) ? read_note_q.pop_front() : '0;
					bin_due_q.push_back(note.fixed ? note.want : resized_bin(int'(req.bin_index)));
				end
			end
			if (rsp_valid && rsp_ready) begin
				if (bin_due_q.size() == 0) begin
					$error("result with none expected: out_real %0d, out_imag %0d",
						rsp.out_real, rsp.out_imag);
					fault_cnt++;
				end else begin
					due = bin_due_q.pop_front();
					if (rsp.out_real !== due.out_real) begin
						$error("out_real: expected %0d, actual %0d", due.out_real, rsp.out_real);
						fault_cnt++;
					end
					if (rsp.out_imag !== due.out_imag) begin
						$error("out_imag: expected %0d, actual %0d", due.out_imag, rsp.out_imag);
						fault_cnt++;
					end
				end
			end
		end
	end

	// Receiver: random ready pattern in spans, with one long hold when asked.
	initial begin : rsp_pacing
		int ready_pct, span;
		ready_pct = 100;
		span = 0;
		forever begin
			@(negedge clk);
			if (hold_rsp_req) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp_req = 1'b0;
			end
			if (span == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pct = 100;
					1: ready_pct = 75;
					2: ready_pct = 50;
					default: ready_pct = 20;
				endcase
				span = $urandom_range(20, 80);
			end
			span--;
			rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
		end
	end

	function automatic logic signed [PART_BITS-1:0] rand_part();
		case ($urandom_range(0, 7))
			0: return P_MAX;
			1: return P_MIN;
			2: return -24'sd1;
			3: return 24'sd0;
			default: return PART_BITS'($urandom());
		endcase
	endfunction

	function automatic req_item_t load_of(input int idx);
		return '{OP_LOAD, IDX_W'(idx), rand_part(), rand_part()};
	endfunction

	function automatic req_item_t read_of(input int k);
		return '{OP_READ, IDX_W'(k), rand_part(), rand_part()};
	endfunction

	// Input bins that output bin k draws on under the current sizes; -1 for none.
	function automatic void source_bins(input int k, output int a, output int b);
		int m, h, q;
		a = -1;
		b = -1;
		m = (gen_ns < gen_nr) ? gen_ns : gen_nr;
		h = (m - 1) / 2;
		if (k >= gen_nr) begin
			a = -1;
		end else if (gen_ns == gen_nr || k <= h) begin
			a = k;
		end else if (k >= gen_nr - h) begin
			a = gen_ns - gen_nr + k;
		end else if (gen_ns % 2 == 0 && gen_nr > gen_ns) begin
			q = gen_ns / 2;
			if (k == q || k == gen_nr - q) begin
				a = q;
			end
		end else if (gen_nr % 2 == 0 && gen_ns > gen_nr) begin
			q = gen_nr / 2;
			if (k == q) begin
				a = q;
				b = gen_ns - q;
			end
		end
	endfunction

	task automatic offer(input req_item_t it, input logic fixed, input rsp_item_t want);
		int gap;
		if (it.operation == OP_READ) begin
			read_note_q.push_back('{fixed, want});
		end else if (int'(it.bin_index) < gen_ns) begin
			bin_filled[it.bin_index] = 1'b1;
		end
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		items_sent++;
		@(negedge clk);
		req_valid <= 1'b1;
		req <= it;
		do @(posedge clk); while (!req_ready);
	endtask

	// Loads any input bin that a read of output bin k would use but that holds nothing yet.
	task automatic load_sources(input int k);
		int a, b;
		source_bins(k, a, b);
		if (a >= 0 && !bin_filled[a]) begin
			offer(load_of(a), 1'b0, '0);
		end
		if (b >= 0 && !bin_filled[b]) begin
			offer(load_of(b), 1'b0, '0);
		end
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		req_valid <= 1'b0;
		while (bin_due_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (bin_due_q.size() != 0) begin
			$error("%0d expected results never arrived", bin_due_q.size());
			fault_cnt++;
			bin_due_q.delete();
		end
		// A load in flight gives no result, so let the pipeline empty before moving on.
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input int value);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= REG_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
		case (sel)
			REG_IN_BINS: gen_ns = bins_in_use(value % (1 << REG_W));
			REG_OUT_BINS: gen_nr = bins_in_use(value % (1 << REG_W));
			default: ;
		endcase
	endtask

	task automatic run_phase(input int ns_raw, input int nr_raw, input int n_items,
		input bit hold);
		int i, k, idx, m, reach;
		write_reg(REG_IN_BINS, ns_raw);
		write_reg(REG_OUT_BINS, nr_raw);
		if (hold) begin
			hold_rsp_req = 1'b1;
		end
		// Well-formed sequences first: a whole spectrum loaded, then every output bin read.
		if (gen_ns <= 32 && $urandom_range(0, 1) == 1) begin
			for (i = 0; i < gen_ns; i++) begin
				offer(load_of(i), 1'b0, '0);
			end
		end
		if (gen_nr <= 32 && $urandom_range(0, 2) != 0) begin
			for (k = 0; k < gen_nr; k++) begin
				load_sources(k);
				offer(read_of(k), 1'b0, '0);
			end
		end
		m = (gen_ns < gen_nr) ? gen_ns : gen_nr;
		reach = (m - 1) / 2 + 2;
		for (i = 0; i < n_items; i++) begin
			if ($urandom_range(0, 19) < 7) begin
				idx = ($urandom_range(0, 6) == 0) ? $urandom_range(0, MAX_BINS - 1)
					: $urandom_range(0, gen_ns - 1);
				offer(load_of(idx), 1'b0, '0);
			end else begin
				case ($urandom_range(0, 9))
					0: k = $urandom_range(0, MAX_BINS - 1);
					1, 2, 3: k = $urandom_range(0, reach);
					4, 5, 6: k = gen_nr - 1 - int'($urandom_range(0, reach));
					7: k = ($urandom_range(0, 1) == 1) ? gen_nr / 2 : gen_nr - gen_ns / 2;
					default: k = $urandom_range(0, gen_nr + 1);
				endcase
				if (k < 0) begin
					k = 0;
				end
				if (k > MAX_BINS - 1) begin
					k = MAX_BINS - 1;
				end
				load_sources(k);
				offer(read_of(k), 1'b0, '0);
			end
		end
	endtask

	initial begin : stimulus
		int i, phase, ns_raw, nr_raw;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		for (i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].is_cfg) begin
				write_reg(PLAN[i].reg_sel, int'(PLAN[i].reg_val));
			end else begin
				if (PLAN[i].item.operation == OP_READ) begin
					load_sources(int'(PLAN[i].item.bin_index));
				end
				offer(PLAN[i].item, PLAN[i].fixed, PLAN[i].want);
			end
		end
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			case (phase)
				0: begin ns_raw = 16; nr_raw = 5; end
				1: begin ns_raw = 5; nr_raw = 16; end
				2: begin ns_raw = MAX_BINS; nr_raw = 2; end
				3: begin ns_raw = 2; nr_raw = MAX_BINS; end
				4: begin ns_raw = 1; nr_raw = 1; end
				5: begin ns_raw = MAX_BINS; nr_raw = MAX_BINS; end
				6: begin ns_raw = 0; nr_raw = 8191; end
				default: begin
					case ($urandom_range(0, 9))
						0: begin ns_raw = MAX_BINS; nr_raw = $urandom_range(1, 40); end
						1: begin ns_raw = $urandom_range(1, 40); nr_raw = MAX_BINS; end
						2: begin ns_raw = $urandom_range(0, 8191); nr_raw = $urandom_range(1, 9); end
						default: begin
							ns_raw = $urandom_range(1, 24);
							nr_raw = ($urandom_range(0, 3) == 0) ? ns_raw : $urandom_range(1, 24);
						end
					endcase
				end
			endcase
			run_phase(ns_raw, nr_raw, $urandom_range(40, 80), phase == 0);
			phase++;
		end
		settle();
		if (fault_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
`default_nettype wire
